### hw/rtl/region_classifier_with_hysteresis_macros.svh
// Assertion macros shared by the region classifier RTL.
// Both macros sample on the rising edge of the clock named clock.

`ifndef REGION_CLASSIFIER_WITH_HYSTERESIS_MACROS_SVH
`define REGION_CLASSIFIER_WITH_HYSTERESIS_MACROS_SVH

// Checked outside of reset only.
`define RCH_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define RCH_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### hw/rtl/rch_pkg.sv
// Package for the region classifier: types, register codes and reset constants.
// No dependencies.
`timescale 1ns / 1ps

package rch_pkg;

   typedef logic signed [15:0] thr_type;

   localparam int NUM_THR_REGS = 6;

   localparam thr_type THR_SAT_MAX = 16'sh7FFF;
   localparam thr_type THR_SAT_MIN = 16'sh8000;

   localparam logic [2:0]  COUNT_RESET  = 3'd6;
   localparam logic [13:0] MARGIN_RESET = 14'd20;
   localparam thr_type THR_RESET [NUM_THR_REGS] =
      '{16'sd0, 16'sd100, 16'sd200, 16'sd350, 16'sd450, 16'sd530};

   // Register indexes, each at byte address 4 * index.
   typedef enum logic [2:0] {
      REG_COUNT  = 3'd0,
      REG_MARGIN = 3'd1,
      REG_THR0   = 3'd2,
      REG_THR1   = 3'd3,
      REG_THR2   = 3'd4,
      REG_THR3   = 3'd5,
      REG_THR4   = 3'd6,
      REG_THR5   = 3'd7
   } reg_idx_type;

   // Configuration as seen by the classifier.
   typedef struct packed {
      logic [2:0]                   count;
      logic [13:0]                  margin;
      thr_type [NUM_THR_REGS-1:0]   def_thr;
   } cfg_type;

   // Threshold write, which also reloads the live copy.
   typedef struct packed {
      logic       valid;
      logic [2:0] idx;
      thr_type    value;
   } thr_wr_type;

endpackage

### hw/rtl/rch_csr.sv
// APB-style register file: threshold count, hysteresis margin, default thresholds.
// Depends on rch_pkg.
`timescale 1ns / 1ps

module rch_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [4:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready,
   output rch_pkg::cfg_type    cfg,
   output rch_pkg::thr_wr_type thr_wr
);
   import rch_pkg::*;

   logic [2:0]  count_ff;
   logic [13:0] margin_ff;
   thr_type     def_ff [NUM_THR_REGS];

   reg_idx_type reg_idx;
   logic        wr_en;
   logic [2:0]  thr_idx;
   logic [2:0]  rd_thr_idx;

   assign pready  = 1'b1;
   assign reg_idx = reg_idx_type'(paddr[4:2]);
   assign wr_en   = psel && penable && pwrite && pready;
   assign thr_idx = paddr[4:2] - 3'(REG_THR0);

   // Threshold write strobe for the live copy in the classifier.
   assign thr_wr.valid = wr_en && (paddr[4:2] >= 3'(REG_THR0));
   assign thr_wr.idx   = thr_idx;
   assign thr_wr.value = pwdata[15:0];

   // Register writes complete at the access phase of a transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= COUNT_RESET;
         margin_ff <= MARGIN_RESET;
         for (int i = 0; i < NUM_THR_REGS; i++) begin
            def_ff[i] <= THR_RESET[i];
         end
      end else if (wr_en) begin
         if (reg_idx == REG_COUNT) begin
            count_ff <= pwdata[2:0];
         end
         if (reg_idx == REG_MARGIN) begin
            margin_ff <= pwdata[13:0];
         end
         for (int i = 0; i < NUM_THR_REGS; i++) begin
            if (thr_wr.valid && thr_idx == 3'(i)) begin
               def_ff[i] <= pwdata[15:0];
            end
         end
      end
   end

   // Configuration bundle.
   always_comb begin
      cfg.count  = count_ff;
      cfg.margin = margin_ff;
      for (int i = 0; i < NUM_THR_REGS; i++) begin
         cfg.def_thr[i] = def_ff[i];
      end
   end

   // Read data; thresholds are sign extended.
   assign rd_thr_idx = thr_idx;

   always_comb begin
      prdata = 32'd0;
      unique case (reg_idx)
         REG_COUNT:  prdata = {29'd0, count_ff};
         REG_MARGIN: prdata = {18'd0, margin_ff};
         REG_THR0, REG_THR1, REG_THR2, REG_THR3, REG_THR4, REG_THR5: begin
            for (int i = 0; i < NUM_THR_REGS; i++) begin
               if (rd_thr_idx == 3'(i)) begin
                  prdata = {{16{def_ff[i][15]}}, def_ff[i]};
               end
            end
         end
      endcase
   end

endmodule

### hw/rtl/rch_core.sv
// Classifier datapath: input register, compare and hysteresis logic, result register.
// Depends on rch_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "region_classifier_with_hysteresis_macros.svh"

module rch_core #(
   parameter int MAX_THRESHOLDS = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  rch_pkg::cfg_type    cfg,
   input  rch_pkg::thr_wr_type thr_wr,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [15:0]  req_temperature,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [2:0]          rsp_region_index,
   output logic                rsp_region_changed
);
   import rch_pkg::*;

   localparam logic [2:0] MAX_W = 3'(MAX_THRESHOLDS);

   // Input stage.
   logic               in_valid_ff, in_valid_in;
   logic signed [15:0] in_temp_ff;

   // Classifier state.
   logic [2:0] cur_region_ff, cur_region_in;
   logic       known_ff, known_in;
   thr_type    live_ff [MAX_THRESHOLDS];
   thr_type    live_in [MAX_THRESHOLDS];

   // Result stage.
   logic       out_valid_ff, out_valid_in;
   logic [2:0] out_region_ff;
   logic       out_changed_ff;

   logic                      advance;
   logic [2:0]                used_n;
   logic [2:0]                idx_c;
   logic                      changed_c;
   logic                      move_down;
   logic                      move_up;
   logic [2:0]                target;
   thr_type                   def_sel;
   logic signed [17:0]        sum_c;
   thr_type                   shifted;
   logic [MAX_THRESHOLDS-1:0] live_moved;

   // An item moves to the result stage when the result register is free or drains.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign out_valid_in = advance ? 1'b1 : (out_valid_ff && !rsp_ready);

   // Count in use, clipped to the number of comparators.
   assign used_n = (cfg.count > MAX_W) ? MAX_W : cfg.count;

   // Priority encode the lowest live threshold not exceeded.
   always_comb begin
      idx_c = used_n;
      for (int i = MAX_THRESHOLDS - 1; i >= 0; i--) begin
         if (3'(i) < used_n && in_temp_ff <= live_ff[i]) begin
            idx_c = 3'(i);
         end
      end
   end

   assign changed_c = known_ff && (idx_c != cur_region_ff);
   assign move_down = changed_c && ({1'b0, idx_c} + 4'd1 == {1'b0, cur_region_ff})
                      && (idx_c < used_n);
   assign move_up   = changed_c && ({1'b0, cur_region_ff} + 4'd1 == {1'b0, idx_c})
                      && (cur_region_ff < used_n);
   assign target    = move_down ? idx_c : cur_region_ff;

   // Shift the crossed boundary's default by the margin, saturating.
   always_comb begin
      def_sel = cfg.def_thr[0];
      for (int i = 0; i < NUM_THR_REGS; i++) begin
         if (target == 3'(i)) begin
            def_sel = cfg.def_thr[i];
         end
      end
   end

   always_comb begin
      if (move_down) begin
         sum_c = $signed({{2{def_sel[15]}}, def_sel}) + $signed({4'b0000, cfg.margin});
      end else begin
         sum_c = $signed({{2{def_sel[15]}}, def_sel}) - $signed({4'b0000, cfg.margin});
      end
   end

   always_comb begin
      priority if (sum_c > $signed({{2{THR_SAT_MAX[15]}}, THR_SAT_MAX})) begin
         shifted = THR_SAT_MAX;
      end else if (sum_c < $signed({{2{THR_SAT_MIN[15]}}, THR_SAT_MIN})) begin
         shifted = THR_SAT_MIN;
      end else begin
         shifted = sum_c[15:0];
      end
   end

   // Next live thresholds: defaults on a change, one shifted on a single step; a threshold write wins.
   always_comb begin
      for (int i = 0; i < MAX_THRESHOLDS; i++) begin
         live_in[i] = live_ff[i];
         if (advance && changed_c) begin
            if ((move_down || move_up) && target == 3'(i)) begin
               live_in[i] = shifted;
            end else begin
               live_in[i] = cfg.def_thr[i];
            end
         end
         if (thr_wr.valid && thr_wr.idx == 3'(i)) begin
            live_in[i] = thr_wr.value;
         end
      end
   end

   assign cur_region_in = advance ? idx_c : cur_region_ff;
   assign known_in      = advance ? 1'b1 : known_ff;

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         cur_region_ff <= 3'd0;
         known_ff      <= 1'b0;
         for (int i = 0; i < MAX_THRESHOLDS; i++) begin
            live_ff[i] <= THR_RESET[i];
         end
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         cur_region_ff <= cur_region_in;
         known_ff      <= known_in;
         for (int i = 0; i < MAX_THRESHOLDS; i++) begin
            live_ff[i] <= live_in[i];
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_temp_ff <= req_temperature;
      end
      if (advance) begin
         out_region_ff  <= idx_c;
         out_changed_ff <= changed_c;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_region_index   = out_region_ff;
   assign rsp_region_changed = out_changed_ff;

   // Entries that currently differ from their defaults.
   always_comb begin
      for (int i = 0; i < MAX_THRESHOLDS; i++) begin
         live_moved[i] = (live_ff[i] != cfg.def_thr[i]);
      end
   end

   `RCH_ASSERT_RST(a_reset_empties, reset |=> !in_valid_ff && !out_valid_ff, "stages busy")
   `RCH_ASSERT(a_state_tracks_out, advance |=> out_region_ff == cur_region_ff, "state mismatch")
   `RCH_ASSERT(a_first_unchanged, advance && !known_ff |=> !out_changed_ff, "first flagged")
   `RCH_ASSERT(a_one_shifted, $countones(live_moved) <= 1, "more than one boundary shifted")
   `RCH_ASSERT(a_region_range, out_valid_ff |-> out_region_ff <= MAX_W, "region too high")

endmodule

### hw/rtl/region_classifier_with_hysteresis.sv
// Top level of the region classifier with hysteresis.
// Depends on rch_pkg, rch_csr and rch_core.
//
//   channel   direction  signals
//   req       in         req_valid, req_ready, req_temperature
//   rsp       out        rsp_valid, rsp_ready, rsp_region_index, rsp_region_changed
//   csr       in/out     psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// One sample per cycle unless a stalled result holds the flow: a sample waits in the
// input register, where the comparator bank, priority encoder and single margin adder
// work on it, and its result moves to the result register, which drives rsp_valid,
// once that register is free or drains.
// Synchronous reset empties both stages and restores registers and thresholds.
// A stalled result holds the result register; the input register still takes one
// more sample, and the request side stalls only when both stages are full.
`timescale 1ns / 1ps

module region_classifier_with_hysteresis #(
   parameter int MAX_THRESHOLDS = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_temperature,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_region_index,
   output logic               rsp_region_changed,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import rch_pkg::*;

   cfg_type    cfg;
   thr_wr_type thr_wr;

   // Register file.
   rch_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg),
      .thr_wr  (thr_wr)
   );

   // Classifier datapath.
   rch_core #(
      .MAX_THRESHOLDS (MAX_THRESHOLDS)
   ) u_core (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .thr_wr             (thr_wr),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_temperature    (req_temperature),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_region_index   (rsp_region_index),
      .rsp_region_changed (rsp_region_changed)
   );

endmodule
